// ----- rtl/sdc_pkg.sv -----
// Shared constants, types and codes for the difference spot centroid block.
// No dependencies; compiled first.
package sdc_pkg;

  localparam int TOP_COUNT  = 4;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int LEVEL_W  = 8;
  localparam int COORD_W  = 12;
  localparam int FWIDTH_W = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam int IDX_W   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int CNT_W   = $clog2(TOP_COUNT + 1);
  localparam int SUM_W   = COORD_W + CNT_W;
  localparam int DSTEP_W = $clog2(SUM_W);

  localparam logic [FWIDTH_W-1:0] WIDTH_RESET     = FWIDTH_W'(640);
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = LEVEL_W'(50);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LEVEL_W-1:0] diff;
  } entry_t;

  typedef struct packed {
    logic             in_ready;
    logic             acc_clear;
    logic             acc_add;
    logic [IDX_W-1:0] acc_idx;
    logic             div_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] filled;
    logic             out_free;
  } sts_t;

endpackage

// ----- rtl/sdc_if.sv -----
// Channel interfaces: pixel input, result output and register write port.
// Depends on sdc_pkg.
interface sdc_in_if import sdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] frame_level;
  logic [LEVEL_W-1:0] base_level;
  logic               frame_end;

  modport source (output valid, frame_level, base_level, frame_end, input ready);
  modport sink   (input valid, frame_level, base_level, frame_end, output ready);
endinterface

interface sdc_out_if import sdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               spot_found;
  logic [COORD_W-1:0] spot_col;
  logic [COORD_W-1:0] spot_row;

  modport source (output valid, spot_found, spot_col, spot_row, input ready);
  modport sink   (input valid, spot_found, spot_col, spot_row, output ready);
endinterface

interface sdc_cfg_if import sdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sdc_ctrl.sv -----
// Sequencer for the difference spot centroid: pixel intake, entry summing,
// division and result hand-off. Depends on sdc_pkg.
module sdc_ctrl import sdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_frame_end,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_LOAD} state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DSTEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.acc_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.acc_clear = 1'b1;
        if (in_valid && in_frame_end) begin
          state_nxt = S_SUM;
          idx_nxt   = '0;
        end
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (!sts.found) begin
          state_nxt = S_LOAD;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == sts.filled) begin
          state_nxt = S_DIV;
          step_nxt  = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DSTEP_W'(SUM_W - 1)) begin
          state_nxt = S_LOAD;
        end else begin
          step_nxt = step_r + DSTEP_W'(1);
        end
      end
      S_LOAD: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- rtl/sdc_datapath.sv -----
// Datapath: registers, raster counters, ranked list, coordinate sums with
// shared-control restoring dividers and the output register. Depends on sdc_pkg.
module sdc_datapath import sdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [LEVEL_W-1:0]    frame_level,
  input  logic [LEVEL_W-1:0]    base_level,
  input  logic                  frame_end,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic                  spot_found,
  output logic [COORD_W-1:0]    spot_col,
  output logic [COORD_W-1:0]    spot_row
);

  logic [FWIDTH_W-1:0] fwidth_r;
  logic [LEVEL_W-1:0]  thr_r;
  logic [COORD_W-1:0]  col_r, row_r;
  logic [CNT_W-1:0]    filled_r;
  entry_t              ent_r    [TOP_COUNT];
  entry_t              ent_nxt  [TOP_COUNT];
  entry_t              ent_prev [TOP_COUNT];
  logic [SUM_W-1:0]    qcol_r, qrow_r, qcol_nxt, qrow_nxt;
  logic [CNT_W-1:0]    rcol_r, rrow_r, rcol_nxt, rrow_nxt;
  logic                out_valid_r, found_r;
  logic [COORD_W-1:0]  ocol_r, orow_r;

  logic                  fire, take, found;
  logic signed [LEVEL_W:0] diff_s;
  entry_t                new_ent;
  logic [TOP_COUNT-1:0]  ge, ge_prev;
  logic [FWIDTH_W-1:0]   col_inc;
  logic [COORD_W:0]      row_inc;
  entry_t                rd_ent;

  assign fire   = in_valid && cmd.in_ready;
  assign diff_s = $signed({1'b0, frame_level}) - $signed({1'b0, base_level});
  assign take   = diff_s > $signed({1'b0, thr_r});
  assign found  = filled_r > CNT_W'(TOP_COUNT / 2);

  assign new_ent.col  = col_r;
  assign new_ent.row  = row_r;
  assign new_ent.diff = diff_s[LEVEL_W-1:0];

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      ge[i] = (CNT_W'(i) < filled_r) && (ent_r[i].diff >= new_ent.diff);
    end
    ge_prev = {ge[TOP_COUNT-2:0], 1'b1};
    ent_prev[0] = new_ent;
    for (int i = 1; i < TOP_COUNT; i++) begin
      ent_prev[i] = ent_r[i-1];
    end
    for (int i = 0; i < TOP_COUNT; i++) begin
      if (ge[i]) begin
        ent_nxt[i] = ent_r[i];
      end else if (ge_prev[i]) begin
        ent_nxt[i] = new_ent;
      end else begin
        ent_nxt[i] = ent_prev[i];
      end
    end
  end

  assign col_inc = FWIDTH_W'(col_r) + FWIDTH_W'(1);
  assign row_inc = {1'b0, row_r} + (COORD_W+1)'(1);

  assign rd_ent = ent_r[cmd.acc_idx];

  function automatic logic [SUM_W+CNT_W-1:0] div_iter(
    input logic [SUM_W-1:0] q,
    input logic [CNT_W-1:0] r,
    input logic [CNT_W-1:0] d
  );
    logic [CNT_W:0]   sh;
    logic             ge_d;
    logic [CNT_W-1:0] r_n;
    sh   = {r, q[SUM_W-1]};
    ge_d = sh >= {1'b0, d};
    r_n  = ge_d ? CNT_W'(sh - {1'b0, d}) : sh[CNT_W-1:0];
    return {q[SUM_W-2:0], ge_d, r_n};
  endfunction

  always_comb begin
    qcol_nxt = qcol_r;
    qrow_nxt = qrow_r;
    rcol_nxt = rcol_r;
    rrow_nxt = rrow_r;
    if (cmd.acc_clear) begin
      qcol_nxt = '0;
      qrow_nxt = '0;
      rcol_nxt = '0;
      rrow_nxt = '0;
    end else if (cmd.acc_add) begin
      qcol_nxt = qcol_r + SUM_W'(rd_ent.col);
      qrow_nxt = qrow_r + SUM_W'(rd_ent.row);
    end else if (cmd.div_step) begin
      {qcol_nxt, rcol_nxt} = div_iter(qcol_r, rcol_r, filled_r);
      {qrow_nxt, rrow_nxt} = div_iter(qrow_r, rrow_r, filled_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r <= WIDTH_RESET;
      thr_r    <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     fwidth_r <= cfg_data[FWIDTH_W-1:0];
        CFG_LEVEL_THRESHOLD: thr_r    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      filled_r <= '0;
    end else begin
      if (cmd.out_load) begin
        filled_r <= '0;
      end else if (fire && take && filled_r < CNT_W'(TOP_COUNT)) begin
        filled_r <= filled_r + CNT_W'(1);
      end
      if (fire) begin
        if (frame_end) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_inc >= fwidth_r || col_inc >= FWIDTH_W'(MAX_WIDTH)) begin
          col_r <= '0;
          row_r <= (row_inc >= (COORD_W+1)'(MAX_HEIGHT)) ? '0 : row_inc[COORD_W-1:0];
        end else begin
          col_r <= col_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && take) begin
      ent_r <= ent_nxt;
    end
    qcol_r <= qcol_nxt;
    qrow_r <= qrow_nxt;
    rcol_r <= rcol_nxt;
    rrow_r <= rrow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r <= found;
      ocol_r  <= found ? qcol_r[COORD_W-1:0] : '0;
      orow_r  <= found ? qrow_r[COORD_W-1:0] : '0;
    end
  end

  assign sts.found    = found;
  assign sts.filled   = filled_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign spot_found = found_r;
  assign spot_col   = ocol_r;
  assign spot_row   = orow_r;

endmodule

// ----- rtl/top_n_difference_spot_centroid.sv -----
// Top level of the difference spot centroid block.
// Depends on sdc_pkg, sdc_if, sdc_ctrl and sdc_datapath.
//
// Channels: in_ch carries one pixel per transaction (current and background
// green level, frame_end on the last pixel of a frame); out_ch carries one
// result per frame; cfg_ch writes frame_width (index 0) and level_threshold
// (index 1) and is always ready. Write registers only while the block is idle.
// Ordinary pixels are taken one per cycle while idle; each pixel whose difference
// exceeds the threshold is ranked into the four-entry list in that cycle.
// A frame_end pixel starts the centroid pass: the coordinates of the filled entries
// are summed one entry at a time (a single summing step and no division when fewer
// than three are filled), then the bit-serial divider runs, then the output
// register is loaded; in_ch is not ready during that pass.
// The output register holds the result until taken; a stalled receiver holds
// the block in its load step only if a previous result is still waiting.
// Reset (rst_n low, synchronous) clears counters, list fill, output valid and
// restores frame_width 640 and level_threshold 50.
module top_n_difference_spot_centroid import sdc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sdc_in_if.sink    in_ch,
  sdc_out_if.source out_ch,
  sdc_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  sdc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .sts          (sts),
    .cmd          (cmd)
  );

  sdc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .frame_level (in_ch.frame_level),
    .base_level  (in_ch.base_level),
    .frame_end   (in_ch.frame_end),
    .cfg_valid   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .spot_found  (out_ch.spot_found),
    .spot_col    (out_ch.spot_col),
    .spot_row    (out_ch.spot_row)
  );

endmodule

// ----- tb/sdc_spot_checker.sv -----
// Checker for the difference spot centroid block: watches the pixel, result and
// register channels, predicts each frame's spot and compares it with the result.
// Depends on sdc_pkg.
module sdc_spot_checker import sdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [LEVEL_W-1:0]    in_frame_level,
  input  logic [LEVEL_W-1:0]    in_base_level,
  input  logic                  in_frame_end,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_spot_found,
  input  logic [COORD_W-1:0]    out_spot_col,
  input  logic [COORD_W-1:0]    out_spot_row,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    spots_due
);

  localparam int SPOT_DEPTH = 8;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } spot_t;

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int                 diff;
  } ranked_t;

  ranked_t              ranked [TOP_COUNT];
  int                   filled;
  logic [COORD_W-1:0]   col_count;
  logic [COORD_W-1:0]   row_count;
  logic [FWIDTH_W-1:0]  width_reg;
  logic [LEVEL_W-1:0]   threshold_reg;
  spot_t                spot_fifo [SPOT_DEPTH];
  int                   wr_ptr;
  int                   rd_ptr;
  int                   pend_count;

  task automatic report_mismatch(input string msg);
    $display("spot mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic track_pixel(input logic [LEVEL_W-1:0] level, input logic [LEVEL_W-1:0] base,
                             input logic last);
    int    diff;
    int    pos;
    int    tail;
    int    col_sum;
    int    row_sum;
    int    next_col;
    spot_t spot;
    diff = int'(level) - int'(base);
    if (diff > int'(threshold_reg)) begin
      pos = 0;
      while (pos < filled && ranked[pos].diff >= diff) pos++;
      if (pos < TOP_COUNT) begin
        tail = (filled < TOP_COUNT) ? filled : TOP_COUNT - 1;
        for (int i = tail; i > pos; i--) ranked[i] = ranked[i-1];
        ranked[pos].col  = col_count;
        ranked[pos].row  = row_count;
        ranked[pos].diff = diff;
        if (filled < TOP_COUNT) filled++;
      end
    end
    if (!last) begin
      next_col = int'(col_count) + 1;
      if (next_col >= int'(width_reg) || next_col >= MAX_WIDTH) begin
        col_count = '0;
        row_count = (int'(row_count) + 1 >= MAX_HEIGHT) ? '0 : row_count + 1'b1;
      end else begin
        col_count = COORD_W'(next_col);
      end
    end else begin
      spot = '0;
      if (filled > TOP_COUNT / 2) begin
        col_sum = 0;
        row_sum = 0;
        for (int i = 0; i < filled; i++) begin
          col_sum += int'(ranked[i].col);
          row_sum += int'(ranked[i].row);
        end
        spot.found = 1'b1;
        spot.col   = COORD_W'(col_sum / filled);
        spot.row   = COORD_W'(row_sum / filled);
      end
      if (pend_count < SPOT_DEPTH) begin
        spot_fifo[wr_ptr] = spot;
        wr_ptr            = (wr_ptr + 1) % SPOT_DEPTH;
        pend_count++;
      end else begin
        report_mismatch("too many results pending");
      end
      filled    = 0;
      col_count = '0;
      row_count = '0;
    end
  endtask

  task automatic check_spot();
    spot_t want;
    if (pend_count == 0) begin
      report_mismatch($sformatf("result with none pending: found %0b col %0d row %0d",
                                out_spot_found, out_spot_col, out_spot_row));
    end else begin
      want   = spot_fifo[rd_ptr];
      rd_ptr = (rd_ptr + 1) % SPOT_DEPTH;
      pend_count--;
      if (out_spot_found !== want.found)
        report_mismatch($sformatf("spot_found got %0b expected %0b", out_spot_found, want.found));
      if (out_spot_col !== want.col)
        report_mismatch($sformatf("spot_col got %0d expected %0d", out_spot_col, want.col));
      if (out_spot_row !== want.row)
        report_mismatch($sformatf("spot_row got %0d expected %0d", out_spot_row, want.row));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches    = 0;
      filled        = 0;
      col_count     = '0;
      row_count     = '0;
      width_reg     = WIDTH_RESET;
      threshold_reg = THRESHOLD_RESET;
      wr_ptr        = 0;
      rd_ptr        = 0;
      pend_count    = 0;
    end else begin
      if (in_valid && in_ready) track_pixel(in_frame_level, in_base_level, in_frame_end);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH)
          width_reg = FWIDTH_W'(cfg_data);
        else if (cfg_index == CFG_LEVEL_THRESHOLD)
          threshold_reg = LEVEL_W'(cfg_data);
      end
      if (out_valid && out_ready) check_spot();
    end
    spots_due <= pend_count;
  end

endmodule

// ----- tb/tb_top_n_difference_spot_centroid.sv -----
// Testbench top for the difference spot centroid block: drives pixel frames and
// register writes with random pacing and gives the verdict.
// Depends on sdc_pkg, sdc_if, the block and sdc_spot_checker.
module tb_top_n_difference_spot_centroid;
  import sdc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(9);
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 30;
  localparam int PHASE_ITEMS  = 135;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   spots_due;
  int   cur_thresh;
  int   burst_left;
  bit   long_hold_due;

  sdc_in_if  in_ch ();
  sdc_out_if out_ch ();
  sdc_cfg_if cfg_ch ();

  top_n_difference_spot_centroid uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sdc_spot_checker spot_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_frame_level (in_ch.frame_level),
    .in_base_level  (in_ch.base_level),
    .in_frame_end   (in_ch.frame_end),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_spot_found (out_ch.spot_found),
    .out_spot_col   (out_ch.spot_col),
    .out_spot_row   (out_ch.spot_row),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .mismatches     (mismatches),
    .spots_due      (spots_due)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_pixel(input int level, input int base, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.frame_level <= LEVEL_W'(level);
    in_ch.base_level  <= LEVEL_W'(base);
    in_ch.frame_end   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_regs(input int width, input int thresh);
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_LEVEL_THRESHOLD, thresh);
    cfg_ch.valid <= 1'b0;
    cur_thresh = thresh;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (spots_due != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic send_random_frame(input int len, input int bright_pct);
    int tie_d;
    int d;
    int base;
    tie_d = (cur_thresh < 255) ? $urandom_range(cur_thresh + 1, 255) : 255;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bright_pct && cur_thresh < 255) begin
        d    = ($urandom_range(0, 3) == 0) ? tie_d : $urandom_range(cur_thresh + 1, 255);
        base = $urandom_range(0, 255 - d);
        send_pixel(base + d, base, i == len - 1);
      end else begin
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255), i == len - 1);
      end
    end
  endtask

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int run;
      int stall;
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (long_hold_due && !hold_done) begin
        hold_done = 1'b1;
        stall     = LONG_HOLD;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int set_width  [8] = '{1, 3, 8, 16, 4096, 0, 8191, 640};
    int set_thresh [8] = '{0, 20, 50, 100, 10, 30, 5, 200};
    int sent;
    int len;
    cur_thresh        = int'(THRESHOLD_RESET);
    burst_left        = 0;
    long_hold_due     = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.frame_level <= '0;
    in_ch.base_level  <= '0;
    in_ch.frame_end   <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, threshold boundary, ties and a full list
    send_pixel(255, 0, 1'b0);
    send_pixel(0, 255, 1'b0);
    send_pixel(100, 50, 1'b0);
    send_pixel(101, 50, 1'b0);
    send_pixel(200, 100, 1'b0);
    send_pixel(200, 100, 1'b0);
    send_pixel(101, 50, 1'b0);
    send_pixel(180, 20, 1'b1);
    send_pixel(0, 0, 1'b1);
    send_pixel(90, 10, 1'b0);
    send_pixel(90, 10, 1'b1);
    send_pixel(60, 0, 1'b0);
    send_pixel(255, 200, 1'b0);
    send_pixel(70, 0, 1'b0);
    // change width and threshold in the middle of a frame
    wait_idle();
    set_regs(1, 0);
    send_pixel(1, 0, 1'b0);
    send_pixel(3, 2, 1'b1);
    wait_idle();
    write_reg(CFG_SPARE_INDEX, 8191);
    set_regs(0, 255);
    send_pixel(255, 0, 1'b0);
    send_pixel(255, 0, 1'b0);
    send_pixel(255, 0, 1'b1);
    wait_idle();
    set_regs(8191, 0);
    send_pixel(128, 127, 1'b0);
    send_pixel(255, 254, 1'b0);
    send_pixel(1, 0, 1'b1);

    for (int s = 0; s < 8; s++) begin
      wait_idle();
      set_regs(set_width[s], set_thresh[s]);
      if (s == 1) long_hold_due = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        send_random_frame(len, $urandom_range(10, 70));
        sent += len;
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- top_n_difference_spot_centroid.f -----
rtl/sdc_pkg.sv
rtl/sdc_if.sv
rtl/sdc_ctrl.sv
rtl/sdc_datapath.sv
rtl/top_n_difference_spot_centroid.sv
tb/sdc_spot_checker.sv
tb/tb_top_n_difference_spot_centroid.sv
